>>> rtl/core/sfd_pkg.sv
`default_nettype none

package sfd_pkg;

   localparam int unsigned BUFFER_DEPTH_DEF = 64;
   localparam int unsigned DATA_W = 8;
   localparam int unsigned IDX_W = 6;

   localparam logic [DATA_W-1:0] HDR_SYNC  = 8'hBA;
   localparam logic [DATA_W-1:0] HDR_MARK  = 8'h98;
   localparam logic [DATA_W-1:0] HDR_END   = 8'h76;
   localparam logic [DATA_W-1:0] TRL_FIRST = 8'h54;
   localparam logic [DATA_W-1:0] TRL_MID   = 8'h32;
   localparam logic [DATA_W-1:0] TRL_END   = 8'h10;

   typedef enum logic [1:0] {
      STAT_DATA     = 2'd0,
      STAT_OVERFLOW = 2'd1,
      STAT_EMPTY    = 2'd2
   } frame_status_type;

   typedef enum logic [2:0] {
      PH_HDR0,
      PH_HDR1,
      PH_HDR2,
      PH_HDR3,
      PH_DATA,
      PH_TRL1,
      PH_TRL2
   } phase_type;

   typedef enum logic [1:0] {
      MODE_RX,
      MODE_READ,
      MODE_LOAD
   } mode_type;

   typedef struct packed {
      logic             store_en;
      logic             count_clr;
      logic             len_load;
      logic             rd_clr;
      logic             rd_inc;
      logic             out_load_data;
      logic             out_load_stat;
      frame_status_type stat_code;
   } dp_cmd_type;

   typedef struct packed {
      logic is_sync;
      logic is_mark;
      logic is_hdr_end;
      logic is_trl_first;
      logic is_trl_mid;
      logic is_trl_end;
      logic full;
      logic len_zero;
      logic rd_last;
      logic out_free;
   } dp_stat_type;

endpackage

`default_nettype wire

>>> rtl/core/serial_frame_deframer.sv
// A status result (overflow or empty frame) is valid the cycle after its byte.
// The first payload byte follows the trailer byte through the READ and LOAD states.
// Throughput: one received byte per cycle outside readout, while the output is free.
// Readout: per payload byte, a READ state for the registered store port, then LOAD.
// Reset: clears the header hunt, store count and output valid; store contents undefined.
`default_nettype none

module serial_frame_deframer #(
   parameter int unsigned BUFFER_DEPTH = sfd_pkg::BUFFER_DEPTH_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [sfd_pkg::DATA_W-1:0] req_rx_byte,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic      [sfd_pkg::DATA_W-1:0] rsp_payload_byte,
   output logic      [sfd_pkg::IDX_W-1:0]  rsp_byte_index,
   output logic      [sfd_pkg::IDX_W-1:0]  rsp_frame_length,
   output logic                            rsp_last_of_frame,
   output logic      [1:0]                 rsp_frame_status
);

   import sfd_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   sfd_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .stat     (stat),
      .cmd      (cmd)
   );

   sfd_dp #(
      .BUFFER_DEPTH(BUFFER_DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .rx_byte          (req_rx_byte),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_frame_length (rsp_frame_length),
      .rsp_last_of_frame(rsp_last_of_frame),
      .rsp_frame_status (rsp_frame_status)
   );

endmodule

`default_nettype wire

>>> rtl/core/sfd_ram.sv
`default_nettype none

module sfd_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/sfd_dp.sv
`default_nettype none

module sfd_dp #(
   parameter int unsigned BUFFER_DEPTH = sfd_pkg::BUFFER_DEPTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [sfd_pkg::DATA_W-1:0]    rx_byte,
   input  wire sfd_pkg::dp_cmd_type           cmd,
   output sfd_pkg::dp_stat_type               stat,
   input  wire logic                          rsp_ready,
   output logic                               rsp_valid,
   output logic      [sfd_pkg::DATA_W-1:0]    rsp_payload_byte,
   output logic      [sfd_pkg::IDX_W-1:0]     rsp_byte_index,
   output logic      [sfd_pkg::IDX_W-1:0]     rsp_frame_length,
   output logic                               rsp_last_of_frame,
   output logic      [1:0]                    rsp_frame_status
);

   import sfd_pkg::*;

   localparam int unsigned AW = $clog2(BUFFER_DEPTH);
   localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1);

   logic [CW-1:0]     count_ff, count_in;
   logic [AW-1:0]     rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]  len_ff, len_in;
   logic [DATA_W-1:0] rd_data;

   logic              valid_ff, valid_in;
   logic [DATA_W-1:0] pb_ff, pb_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [IDX_W-1:0]  flen_ff, flen_in;
   logic              last_ff, last_in;
   frame_status_type  st_ff, st_in;

   sfd_ram #(
      .WIDTH(DATA_W),
      .DEPTH(BUFFER_DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (cmd.store_en),
      .wr_addr(count_ff[AW-1:0]),
      .wr_data(rx_byte),
      .rd_addr(rd_idx_ff),
      .rd_data(rd_data)
   );

   always_comb begin
      stat.is_sync      = (rx_byte == HDR_SYNC);
      stat.is_mark      = (rx_byte == HDR_MARK);
      stat.is_hdr_end   = (rx_byte == HDR_END);
      stat.is_trl_first = (rx_byte == TRL_FIRST);
      stat.is_trl_mid   = (rx_byte == TRL_MID);
      stat.is_trl_end   = (rx_byte == TRL_END);
      stat.full         = (count_ff >= CW'(BUFFER_DEPTH));
      stat.len_zero     = (count_ff <= CW'(2));
      stat.rd_last      = ((IDX_W'(rd_idx_ff) + IDX_W'(1)) == len_ff);
      stat.out_free     = !valid_ff || rsp_ready;
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.count_clr) begin
         count_in = '0;
      end else if (cmd.store_en) begin
         count_in = count_ff + CW'(1);
      end

      len_in = len_ff;
      if (cmd.len_load) begin
         len_in = IDX_W'(count_ff - CW'(2));
      end

      rd_idx_in = rd_idx_ff;
      if (cmd.rd_clr) begin
         rd_idx_in = '0;
      end else if (cmd.rd_inc) begin
         rd_idx_in = rd_idx_ff + AW'(1);
      end

      valid_in = valid_ff;
      pb_in    = pb_ff;
      idx_in   = idx_ff;
      flen_in  = flen_ff;
      last_in  = last_ff;
      st_in    = st_ff;
      if (valid_ff && rsp_ready) begin
         valid_in = 1'b0;
      end
      if (cmd.out_load_data) begin
         valid_in = 1'b1;
         pb_in    = rd_data;
         idx_in   = IDX_W'(rd_idx_ff);
         flen_in  = len_ff;
         last_in  = stat.rd_last;
         st_in    = STAT_DATA;
      end else if (cmd.out_load_stat) begin
         valid_in = 1'b1;
         pb_in    = '0;
         idx_in   = '0;
         flen_in  = '0;
         last_in  = 1'b1;
         st_in    = cmd.stat_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         rd_idx_ff <= '0;
         valid_ff  <= 1'b0;
      end else begin
         count_ff  <= count_in;
         rd_idx_ff <= rd_idx_in;
         valid_ff  <= valid_in;
      end
      len_ff  <= len_in;
      pb_ff   <= pb_in;
      idx_ff  <= idx_in;
      flen_ff <= flen_in;
      last_ff <= last_in;
      st_ff   <= st_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_payload_byte  = pb_ff;
   assign rsp_byte_index    = idx_ff;
   assign rsp_frame_length  = flen_ff;
   assign rsp_last_of_frame = last_ff;
   assign rsp_frame_status  = st_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(BUFFER_DEPTH))
      else $error("store count beyond depth");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load_data || cmd.out_load_stat) |-> stat.out_free)
      else $error("output register overwritten");

   a_last_marked: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load_data && stat.rd_last) |=> (valid_ff && last_ff))
      else $error("final byte not marked");
`endif

endmodule

`default_nettype wire

>>> rtl/core/sfd_ctrl.sv
`default_nettype none

module sfd_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire sfd_pkg::dp_stat_type stat,
   output sfd_pkg::dp_cmd_type       cmd
);

   import sfd_pkg::*;

   phase_type phase_ff, phase_in;
   mode_type  mode_ff, mode_in;
   logic      accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HDR0;
         mode_ff  <= MODE_RX;
      end else begin
         phase_ff <= phase_in;
         mode_ff  <= mode_in;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      mode_in   = mode_ff;
      cmd       = '0;
      cmd.stat_code = STAT_DATA;
      req_ready = (mode_ff == MODE_RX) && stat.out_free;
      accept    = req_valid && req_ready;

      case (mode_ff)
         MODE_RX: begin
            if (accept) begin
               case (phase_ff)
                  PH_HDR0: begin
                     if (stat.is_sync) begin
                        phase_in = PH_HDR1;
                     end
                  end
                  PH_HDR1: begin
                     if (stat.is_sync) begin
                        phase_in = PH_HDR2;
                     end else if (stat.is_mark) begin
                        phase_in = PH_HDR3;
                     end else begin
                        phase_in = PH_HDR0;
                     end
                  end
                  PH_HDR2: begin
                     phase_in = stat.is_mark ? PH_HDR3 : PH_HDR0;
                  end
                  PH_HDR3: begin
                     if (stat.is_hdr_end) begin
                        phase_in      = PH_DATA;
                        cmd.count_clr = 1'b1;
                     end else begin
                        phase_in = PH_HDR0;
                     end
                  end
                  PH_DATA, PH_TRL1: begin
                     if (stat.full) begin
                        phase_in          = PH_HDR0;
                        cmd.count_clr     = 1'b1;
                        cmd.out_load_stat = 1'b1;
                        cmd.stat_code     = STAT_OVERFLOW;
                     end else begin
                        cmd.store_en = 1'b1;
                        if (phase_ff == PH_DATA) begin
                           phase_in = stat.is_trl_first ? PH_TRL1 : PH_DATA;
                        end else begin
                           phase_in = stat.is_trl_mid ? PH_TRL2 : PH_DATA;
                        end
                     end
                  end
                  PH_TRL2: begin
                     if (stat.is_trl_end) begin
                        phase_in      = PH_HDR0;
                        cmd.count_clr = 1'b1;
                        cmd.len_load  = 1'b1;
                        if (stat.len_zero) begin
                           cmd.out_load_stat = 1'b1;
                           cmd.stat_code     = STAT_EMPTY;
                        end else begin
                           cmd.rd_clr = 1'b1;
                           mode_in    = MODE_READ;
                        end
                     end else if (stat.full) begin
                        phase_in          = PH_HDR0;
                        cmd.count_clr     = 1'b1;
                        cmd.out_load_stat = 1'b1;
                        cmd.stat_code     = STAT_OVERFLOW;
                     end else begin
                        cmd.store_en = 1'b1;
                        phase_in     = PH_DATA;
                     end
                  end
                  default: begin
                     phase_in      = PH_HDR0;
                     cmd.count_clr = 1'b1;
                  end
               endcase
            end
         end
         MODE_READ: begin
            mode_in = MODE_LOAD;
         end
         MODE_LOAD: begin
            if (stat.out_free) begin
               cmd.out_load_data = 1'b1;
               if (stat.rd_last) begin
                  mode_in = MODE_RX;
               end else begin
                  cmd.rd_inc = 1'b1;
                  mode_in    = MODE_READ;
               end
            end
         end
         default: begin
            mode_in = MODE_RX;
         end
      endcase
   end

`ifndef NO_ASSERTIONS
   a_frame_to_read: assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff == PH_TRL2 && stat.is_trl_end && !stat.len_zero)
      |=> (mode_ff == MODE_READ))
      else $error("completed frame not read out");

   a_read_to_load: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_READ) |=> (mode_ff == MODE_LOAD))
      else $error("read wait skipped");

   a_last_to_rx: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_LOAD && stat.out_free && stat.rd_last)
      |=> (mode_ff == MODE_RX && phase_ff == PH_HDR0))
      else $error("readout did not return to hunt");

   a_no_store_in_read: assert property (@(posedge clock) disable iff (reset)
      (mode_ff != MODE_RX) |-> !(cmd.store_en || cmd.count_clr))
      else $error("store touched during readout");
`endif

endmodule

`default_nettype wire

>>> verif/serial_frame_deframer_checker.sv
`timescale 1ns / 1ps

module serial_frame_deframer_checker #(
   parameter int unsigned BUFFER_DEPTH = sfd_pkg::BUFFER_DEPTH_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire logic                       req_ready,
   input  wire logic [sfd_pkg::DATA_W-1:0] req_rx_byte,
   input  wire logic                       rsp_valid,
   input  wire logic                       rsp_ready,
   input  wire logic [sfd_pkg::DATA_W-1:0] rsp_payload_byte,
   input  wire logic [sfd_pkg::IDX_W-1:0]  rsp_byte_index,
   input  wire logic [sfd_pkg::IDX_W-1:0]  rsp_frame_length,
   input  wire logic                       rsp_last_of_frame,
   input  wire logic [1:0]                 rsp_frame_status,
   output int unsigned                     due_count,
   output int unsigned                     error_count
);

   import sfd_pkg::*;

   typedef struct packed {
      logic [DATA_W-1:0] payload_byte;
      logic [IDX_W-1:0]  byte_index;
      logic [IDX_W-1:0]  frame_length;
      logic              last_of_frame;
      logic [1:0]        frame_status;
   } deframed_beat_type;

   deframed_beat_type beats_due[$];
   phase_type         rx_phase = PH_HDR0;
   logic [DATA_W-1:0] frame_copy [BUFFER_DEPTH];
   int unsigned       held_count = 0;
   int unsigned       errors = 0;

   function automatic deframed_beat_type status_beat(input frame_status_type st);
      deframed_beat_type s;
      s = '0;
      s.last_of_frame = 1'b1;
      s.frame_status = st;
      return s;
   endfunction

   // store the byte, or drop the frame when the store is already full
   task automatic keep_byte(input logic [DATA_W-1:0] b, input phase_type nxt);
      if (held_count >= BUFFER_DEPTH) begin
         beats_due.push_back(status_beat(STAT_OVERFLOW));
         rx_phase = PH_HDR0;
         held_count = 0;
      end else begin
         frame_copy[held_count] = b;
         held_count++;
         rx_phase = nxt;
      end
   endtask

   task automatic track_rx_byte(input logic [DATA_W-1:0] b);
      int unsigned       len;
      int unsigned       k;
      deframed_beat_type d;
      case (rx_phase)
         PH_HDR0: begin
            if (b == HDR_SYNC) rx_phase = PH_HDR1;
         end
         PH_HDR1: begin
            if (b == HDR_SYNC) rx_phase = PH_HDR2;
            else if (b == HDR_MARK) rx_phase = PH_HDR3;
            else rx_phase = PH_HDR0;
         end
         PH_HDR2: begin
            if (b == HDR_MARK) rx_phase = PH_HDR3;
            else rx_phase = PH_HDR0;
         end
         PH_HDR3: begin
            if (b == HDR_END) begin
               rx_phase = PH_DATA;
               held_count = 0;
            end else begin
               rx_phase = PH_HDR0;
            end
         end
         PH_DATA: keep_byte(b, (b == TRL_FIRST) ? PH_TRL1 : PH_DATA);
         PH_TRL1: keep_byte(b, (b == TRL_MID) ? PH_TRL2 : PH_DATA);
         PH_TRL2: begin
            if (b == TRL_END) begin
               len = (held_count >= 2) ? held_count - 2 : 0;
               rx_phase = PH_HDR0;
               held_count = 0;
               if (len == 0) begin
                  beats_due.push_back(status_beat(STAT_EMPTY));
               end else begin
                  for (k = 0; k < len; k++) begin
                     d.payload_byte = frame_copy[k];
                     d.byte_index = IDX_W'(k);
                     d.frame_length = IDX_W'(len);
                     d.last_of_frame = (k == len - 1);
                     d.frame_status = STAT_DATA;
                     beats_due.push_back(d);
                  end
               end
            end else begin
               keep_byte(b, PH_DATA);
            end
         end
         default: begin
            rx_phase = PH_HDR0;
            held_count = 0;
         end
      endcase
   endtask

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : watch
      deframed_beat_type want;
      if (reset) begin
         rx_phase = PH_HDR0;
         held_count = 0;
         beats_due.delete();
      end else begin
         if (req_valid && req_ready) track_rx_byte(req_rx_byte);
         if (rsp_valid && rsp_ready) begin
            if (beats_due.size() == 0) begin
               $error("result beat with nothing due: payload_byte 0x%0h status %0d",
                      rsp_payload_byte, rsp_frame_status);
               errors++;
            end else begin
               want = beats_due.pop_front();
               compare_field("payload_byte", want.payload_byte, rsp_payload_byte);
               compare_field("byte_index", want.byte_index, rsp_byte_index);
               compare_field("frame_length", want.frame_length, rsp_frame_length);
               compare_field("last_of_frame", want.last_of_frame, rsp_last_of_frame);
               compare_field("frame_status", want.frame_status, rsp_frame_status);
            end
         end
      end
      due_count <= beats_due.size();
      error_count <= errors;
   end

endmodule

>>> verif/serial_frame_deframer_tb.sv
`timescale 1ns / 1ps

module serial_frame_deframer_tb;
   import sfd_pkg::*;

   localparam logic [DATA_W-1:0] DIRECTED [28] = '{
      8'h00, 8'hFF, HDR_SYNC, 8'h11, HDR_SYNC, HDR_SYNC, HDR_MARK, 8'h00,
      HDR_SYNC, HDR_MARK, HDR_END, TRL_FIRST, TRL_MID, TRL_END,
      HDR_SYNC, HDR_SYNC, HDR_MARK, HDR_END,
      8'h00, TRL_FIRST, 8'h00, TRL_FIRST, TRL_MID, 8'h00, 8'hFF,
      TRL_FIRST, TRL_MID, TRL_END
   };

   logic              clock;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic [DATA_W-1:0] req_rx_byte = '0;
   logic              rsp_ready = 1'b0;
   logic              req_ready;
   logic              rsp_valid;
   logic [DATA_W-1:0] rsp_payload_byte;
   logic [IDX_W-1:0]  rsp_byte_index;
   logic [IDX_W-1:0]  rsp_frame_length;
   logic              rsp_last_of_frame;
   logic [1:0]        rsp_frame_status;
   int unsigned       due_count;
   int unsigned       error_count;

   bit                quiet = 1'b0;
   int unsigned       idle_pct = 30;
   int unsigned       items_sent = 0;
   int unsigned       ready_run = 0;

   serial_frame_deframer i_dut (.*);

   serial_frame_deframer_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // stall the result side in bursts, hold ready high once quiet
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         ready_run <= 0;
      end else if (quiet) begin
         rsp_ready <= 1'b1;
      end else if (ready_run == 0) begin
         if ($urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            ready_run <= $urandom_range(1, 17);
         end else begin
            rsp_ready <= 1'b1;
            ready_run <= $urandom_range(1, 40);
         end
      end else begin
         ready_run <= ready_run - 1;
      end
   end

   task automatic send_beat(input logic [DATA_W-1:0] b);
      if (!quiet && $urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_header();
      send_beat(HDR_SYNC);
      if ($urandom_range(0, 2) != 0) send_beat(HDR_SYNC);
      send_beat(HDR_MARK);
      send_beat(HDR_END);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (due_count != 0) @(posedge clock);
   endtask

   function automatic logic [DATA_W-1:0] pick_byte();
      case ($urandom_range(0, 9))
         0: return TRL_FIRST;
         1: return TRL_MID;
         2: return TRL_END;
         3: return HDR_SYNC;
         default: return DATA_W'($urandom);
      endcase
   endfunction

   initial begin : stimulus
      int unsigned       len;
      int unsigned       k;
      int unsigned       kind;
      bit                paused;
      logic [DATA_W-1:0] b;
      paused = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i]) send_beat(DIRECTED[i]);
      wait_drained();

      while (items_sent < 350) begin
         if (items_sent >= 300) quiet <= 1'b1;
         if (!paused && items_sent >= 175) begin
            wait_drained();
            paused = 1'b1;
         end
         case ($urandom_range(0, 2))
            0: idle_pct = 0;
            1: idle_pct = 15;
            default: idle_pct = 40;
         endcase
         kind = $urandom_range(0, 99);
         if (kind < 70) begin
            send_header();
            if ($urandom_range(0, 9) == 0)
               len = ($urandom_range(0, 2) == 0) ? 62 : $urandom_range(40, 62);
            else
               len = $urandom_range(0, 8);
            for (k = 0; k < len; k++) begin
               b = pick_byte();
               if (k == len - 1 && b == TRL_FIRST) b = TRL_MID;
               send_beat(b);
            end
            send_beat(TRL_FIRST);
            send_beat(TRL_MID);
            send_beat(TRL_END);
         end else if (kind < 74) begin
            send_header();
            repeat ($urandom_range(65, 70)) begin
               b = DATA_W'($urandom);
               if (b == TRL_FIRST) b = 8'h55;
               send_beat(b);
            end
         end else if (kind < 87) begin
            b = DATA_W'($urandom);
            if (b == HDR_END) b = 8'h00;
            case ($urandom_range(0, 3))
               0: begin
                  send_beat(HDR_SYNC);
                  send_beat(HDR_SYNC);
                  send_beat(HDR_SYNC);
               end
               1: begin
                  send_beat(HDR_SYNC);
                  send_beat(HDR_SYNC);
                  send_beat(HDR_MARK);
                  send_beat(b);
               end
               2: begin
                  send_beat(HDR_SYNC);
                  send_beat(b);
               end
               default: begin
                  send_beat(HDR_SYNC);
                  send_beat(HDR_MARK);
                  send_beat(b);
               end
            endcase
         end else begin
            repeat ($urandom_range(1, 6)) send_beat(pick_byte());
         end
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
